@@ rtl/cle_pkg.sv @@
// Package for the line editor: key codes, result kinds and record, register indexes
// and the sequencer state type. No dependencies.
package cle_pkg;

  localparam logic [7:0] KEY_INTR   = 8'h03;
  localparam logic [7:0] KEY_EOF    = 8'h04;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_TAB    = 8'h09;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_KILL   = 8'h15;
  localparam logic [7:0] KEY_WERASE = 8'h17;
  localparam logic [7:0] KEY_SUSP   = 8'h1A;
  localparam logic [7:0] KEY_QUIT   = 8'h1C;
  localparam logic [7:0] KEY_SPACE  = 8'h20;
  localparam logic [7:0] KEY_ERASE  = 8'h7F;
  localparam logic [7:0] KEY_UP     = 8'h80;
  localparam logic [7:0] KEY_DOWN   = 8'h81;
  localparam logic [7:0] KEY_LEFT   = 8'h82;
  localparam logic [7:0] KEY_RIGHT  = 8'h83;
  localparam logic [7:0] KEY_HOME   = 8'h84;
  localparam logic [7:0] KEY_END    = 8'h85;
  localparam logic [7:0] KEY_DEL    = 8'h86;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_INTR = 2'd1;
  localparam logic [1:0] KIND_QUIT = 2'd2;
  localparam logic [1:0] KIND_FWD  = 2'd3;

  localparam logic CFG_CANON  = 1'b0;
  localparam logic CFG_SIGNAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT1,
    ST_INS,
    ST_CUT,
    ST_WSKIPSP,
    ST_WSKIPWD,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       empty;
    logic       last;
  } result_t;

endpackage

@@ rtl/cle_ram.sv @@
// Edit buffer storage: one write port, one registered read port.
// Depends on nothing.
module cle_ram #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  // Write and read, both registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/canonical_line_editor.sv @@
// Top level of the line editor: sequencer around one edit buffer memory.
// Depends on cle_pkg and cle_ram.
//
//  channel | direction | handshake    | payload
//  key     | in        | valid/stall  | key_code
//  result  | out       | valid/stall  | result_kind, data_byte, line_empty, is_last
//  cfg     | in        | valid/ready  | cfg_index, cfg_data
//
// Edit keys that touch no stored character are handled in the idle state. Insert
// and the cuts move one character at a time (memory read then write); word
// erase scans back one entry at a time; a committed line streams one character
// at a time. No new key is taken until the sequencer is back in idle.
// Reset is synchronous; buffer contents are not cleared. A stalled result holds
// its register; the sequencer waits on it when it has a further result to load,
// and cfg is not taken while it is full.
module canonical_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] data_byte,
  output logic       line_empty,
  output logic       is_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [0:0] cfg_data
);
  localparam int AW = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [AW-1:0] MAXLEN = AW'(LINE_CAPACITY - 1);

  cle_pkg::state_t state, state_next;
  logic [AW-1:0] len, len_next, cur, cur_next, ptr, ptr_next, lim, lim_next;
  logic [AW-1:0] gap, gap_next;
  logic [7:0] key, key_next;
  logic phase, phase_next;
  logic canon, sig_en;
  logic out_full;
  cle_pkg::result_t res, res_next;
  cle_pkg::result_t pend, pend_next;
  logic load;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic accept;

  cle_ram #(.DEPTH(LINE_CAPACITY), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != cle_pkg::ST_IDLE);
  assign cfg_ready = (state == cle_pkg::ST_IDLE) && !out_full;
  assign out_valid = out_full;
  assign result_kind = res.kind;
  assign data_byte   = res.data;
  assign line_empty  = res.empty;
  assign is_last     = res.last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canon  <= 1'b1;
      sig_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cle_pkg::CFG_CANON) canon <= cfg_data[0];
      else sig_en <= cfg_data[0];
    end
  end

  // Sequencer: next state, counters, memory access and result load
  always_comb begin
    state_next = state;
    len_next = len; cur_next = cur; ptr_next = ptr; lim_next = lim;
    key_next = key; phase_next = phase;
    load = 1'b0;
    res_next = res;
    pend_next = pend;
    we = 1'b0; waddr = ptr; wdata = rdata; raddr = ptr;
    unique case (state)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          key_next = key_code;
          phase_next = 1'b0;
          pend_next = '{kind: cle_pkg::KIND_CHAR, data: 8'd0, empty: 1'b0, last: 1'b1};
          if (sig_en && (key_code == cle_pkg::KEY_INTR || key_code == cle_pkg::KEY_QUIT))
          begin
            len_next = '0; cur_next = '0;
            pend_next.kind = (key_code == cle_pkg::KEY_INTR) ? cle_pkg::KIND_INTR
                                                             : cle_pkg::KIND_QUIT;
            state_next = cle_pkg::ST_EMIT1;
          end else if (sig_en && key_code == cle_pkg::KEY_SUSP) begin
            state_next = cle_pkg::ST_IDLE;
          end else if (!canon) begin
            pend_next.data = key_code;
            state_next = cle_pkg::ST_EMIT1;
          end else begin
            unique case (key_code)
              cle_pkg::KEY_UP, cle_pkg::KEY_DOWN, cle_pkg::KEY_TAB: begin
                pend_next.kind = cle_pkg::KIND_FWD;
                pend_next.data = key_code;
                state_next = cle_pkg::ST_EMIT1;
              end
              cle_pkg::KEY_LEFT:  if (cur != '0) cur_next = cur - 1'b1;
              cle_pkg::KEY_RIGHT: if (cur < len) cur_next = cur + 1'b1;
              cle_pkg::KEY_HOME:  cur_next = '0;
              cle_pkg::KEY_END:   cur_next = len;
              cle_pkg::KEY_DEL: begin
                if (cur < len) begin
                  lim_next = cur; ptr_next = cur + 1'b1;
                  state_next = cle_pkg::ST_CUT;
                end
              end
              cle_pkg::KEY_LF, cle_pkg::KEY_CR, cle_pkg::KEY_EOF: begin
                if (len == '0) begin
                  pend_next.empty = 1'b1;
                  state_next = cle_pkg::ST_EMIT1;
                end else begin
                  ptr_next = '0;
                  state_next = cle_pkg::ST_STREAM;
                end
              end
              cle_pkg::KEY_ERASE, cle_pkg::KEY_BS: begin
                if (cur != '0) begin
                  lim_next = cur - 1'b1; ptr_next = cur;
                  state_next = cle_pkg::ST_CUT;
                end
              end
              cle_pkg::KEY_KILL: begin
                len_next = '0; cur_next = '0;
              end
              cle_pkg::KEY_WERASE: begin
                ptr_next = cur;
                state_next = cle_pkg::ST_WSKIPSP;
              end
              default: begin
                if (len < MAXLEN) begin
                  ptr_next = len;
                  state_next = cle_pkg::ST_INS;
                end
              end
            endcase
          end
        end
      end
      cle_pkg::ST_EMIT1: begin
        if (!out_full) begin
          load = 1'b1;
          res_next = pend;
          state_next = cle_pkg::ST_IDLE;
        end
      end
      // Shift right from the end down to the cursor, then place the key
      cle_pkg::ST_INS: begin
        if (ptr == cur) begin
          we = 1'b1; waddr = cur; wdata = key;
          len_next = len + 1'b1; cur_next = cur + 1'b1;
          state_next = cle_pkg::ST_IDLE;
        end else begin
          raddr = ptr - 1'b1;
          if (!phase) phase_next = 1'b1;
          else begin
            we = 1'b1; waddr = ptr; wdata = rdata;
            ptr_next = ptr - 1'b1; phase_next = 1'b0;
          end
        end
      end
      // Close the gap [lim, lim+gap): copy entry ptr to ptr-gap
      cle_pkg::ST_CUT: begin
        if (ptr == len) begin
          len_next = len - gap;
          cur_next = lim;
          state_next = cle_pkg::ST_IDLE;
        end else begin
          raddr = ptr;
          if (!phase) phase_next = 1'b1;
          else begin
            we = 1'b1; waddr = ptr - gap; wdata = rdata;
            ptr_next = ptr + 1'b1;
            phase_next = 1'b0;
          end
        end
      end
      // Word erase: skip spaces, then the word, scanning back
      cle_pkg::ST_WSKIPSP, cle_pkg::ST_WSKIPWD: begin
        if (ptr == '0) begin
          lim_next = '0; ptr_next = cur;
          state_next = cle_pkg::ST_CUT;
        end else begin
          raddr = ptr - 1'b1;
          if (!phase) phase_next = 1'b1;
          else begin
            phase_next = 1'b0;
            if (state == cle_pkg::ST_WSKIPSP) begin
              if (rdata == cle_pkg::KEY_SPACE) ptr_next = ptr - 1'b1;
              else state_next = cle_pkg::ST_WSKIPWD;
            end else begin
              if (rdata != cle_pkg::KEY_SPACE) ptr_next = ptr - 1'b1;
              else begin
                lim_next = ptr; ptr_next = cur;
                state_next = cle_pkg::ST_CUT;
              end
            end
          end
        end
      end
      // Stream the line out, one read per character
      cle_pkg::ST_STREAM: begin
        raddr = ptr;
        if (!phase) phase_next = 1'b1;
        else if (!out_full) begin
          load = 1'b1;
          res_next = '{kind: cle_pkg::KIND_CHAR, data: rdata, empty: 1'b0,
                       last: (ptr + 1'b1 == len)};
          phase_next = 1'b0;
          ptr_next = ptr + 1'b1;
          if (ptr + 1'b1 == len) begin
            len_next = '0; cur_next = '0;
            state_next = cle_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = cle_pkg::ST_IDLE;
    endcase
  end

  // Cut bookkeeping: capture the gap width on entry
  always_comb begin
    gap_next = gap;
    if (state != cle_pkg::ST_CUT && state_next == cle_pkg::ST_CUT)
      gap_next = ptr_next - lim_next;
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cle_pkg::ST_IDLE;
      len <= '0; cur <= '0; ptr <= '0; lim <= '0; gap <= '0;
      phase <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_next; cur <= cur_next; lim <= lim_next; gap <= gap_next;
      phase <= phase_next;
      ptr <= ptr_next;
      if (load) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key  <= key_next;
    pend <= pend_next;
    if (load) res <= res_next;
  end

  // Assertions
  a_cur_le_len: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond length");
  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= MAXLEN)
    else $error("length beyond capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_full && out_stall |=> out_full && $stable(res))
    else $error("result changed while stalled");
endmodule
